/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

/* rtl/tvp_pkg.sv */
// ----------------------------------------------------------------------------
// tvp_pkg
// Types and constants shared by the velocity profile controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tvp_pkg;

	// register indexes on the configuration port
	localparam int CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_VEL = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TICK = 8'd3;

	// register reset values
	localparam logic [31:0] ACCEL_RESET = 32'd65536;
	localparam logic [15:0] TICK_RESET = 16'd655;

	// below this many counts to go the command is zero
	localparam int NEAR_GOAL_COUNTS = 10;

	// datapath operations, one per controller step
	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_STEP,
		OP_VSQ,
		OP_DIST,
		OP_CMP,
		OP_CAND,
		OP_FINISH
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic out_busy;
	} dp_status_t;

endpackage

`default_nettype wire

/* rtl/tvp_ctrl.sv */
// ----------------------------------------------------------------------------
// tvp_ctrl
// Sequencer: steps the shared multiplier and the update through one request.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tvp_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire tvp_pkg::dp_status_t status,
	output tvp_pkg::dp_cmd_t         cmd
);
	import tvp_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_STEP = 7'b0000010,
		S_VSQ  = 7'b0000100,
		S_DIST = 7'b0001000,
		S_CMP  = 7'b0010000,
		S_CAND = 7'b0100000,
		S_DONE = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign in_stall = (state_q != S_IDLE);
	assign accept = in_valid && !in_stall;

	always_comb begin
		state_d = state_q;
		cmd.op = OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.op = OP_LOAD;
					state_d = S_STEP;
				end
			end
			S_STEP: begin
				cmd.op = OP_STEP;
				state_d = S_VSQ;
			end
			S_VSQ: begin
				cmd.op = OP_VSQ;
				state_d = S_DIST;
			end
			S_DIST: begin
				cmd.op = OP_DIST;
				state_d = S_CMP;
			end
			S_CMP: begin
				cmd.op = OP_CMP;
				state_d = S_CAND;
			end
			S_CAND: begin
				cmd.op = OP_CAND;
				state_d = S_DONE;
			end
			S_DONE: begin
				// hold the result until the output register is free
				if (!status.out_busy) begin
					cmd.op = OP_FINISH;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`ASSERT_NEXT(a_accept_starts, clk, arst_n, accept, state_q == S_STEP)
	`ASSERT_NEXT(a_done_returns, clk, arst_n, (state_q == S_DONE) && !status.out_busy, state_q == S_IDLE)

endmodule

`default_nettype wire

/* rtl/tvp_datapath.sv */
// ----------------------------------------------------------------------------
// tvp_datapath
// Shared 32x32 multiplier, braking test, speed update and output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tvp_datapath (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire tvp_pkg::dp_cmd_t    cmd,
	output tvp_pkg::dp_status_t      status,
	input  wire logic signed [31:0]  position,
	input  wire logic signed [31:0]  target_q,
	input  wire logic [31:0]         max_q,
	input  wire logic [31:0]         accel_q,
	input  wire logic [15:0]         tick_q,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [31:0]              velocity_ref
);
	import tvp_pkg::*;

	logic signed [32:0] rem_q;
	logic [63:0]        prod_q;
	logic [31:0]        step_q;
	logic [46:0]        rhs_q;
	logic               room_q;
	logic [32:0]        cand_q;
	logic [31:0]        speed_q;
	logic [31:0]        vel_q;
	logic               out_valid_q;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic        rem_pos;
	logic        near;
	logic [32:0] rise;
	logic [32:0] cand_d;
	logic [31:0] result;

	assign rem_pos = !rem_q[32] && (rem_q != '0);
	assign near = rem_q < $signed(33'(NEAR_GOAL_COUNTS));
	assign rise = {1'b0, speed_q} + {1'b0, step_q};

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			OP_STEP: begin
				mul_a = accel_q;
				mul_b = {16'b0, tick_q};
			end
			OP_VSQ: begin
				mul_a = speed_q;
				mul_b = speed_q;
			end
			OP_DIST: begin
				// only meaningful when rem > 0, then it fits 32 bits
				mul_a = rem_q[31:0];
				mul_b = accel_q;
			end
			OP_NONE, OP_LOAD, OP_CMP, OP_CAND, OP_FINISH: begin
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		if (room_q) begin
			cand_d = (speed_q < max_q) ? rise : {1'b0, speed_q};
		end else begin
			cand_d = (speed_q >= step_q) ? {1'b0, speed_q - step_q} : '0;
		end
	end

	always_comb begin
		if (near) begin
			result = '0;
		end else if (cand_q > {1'b0, max_q}) begin
			result = max_q;
		end else begin
			result = cand_q[31:0];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				rem_q <= {target_q[31], target_q} - {position[31], position};
			end
			OP_STEP: begin
				prod_q <= mul_a * mul_b;
			end
			OP_VSQ: begin
				step_q <= prod_q[47:16];
				prod_q <= mul_a * mul_b;
			end
			OP_DIST: begin
				rhs_q <= prod_q[63:17];
				prod_q <= mul_a * mul_b;
			end
			OP_CMP: begin
				// rem*a > floor(v*v / 2^17) is the same test as rem > rhs / a
				room_q <= rem_pos && (prod_q > {17'b0, rhs_q});
			end
			OP_CAND: begin
				cand_q <= cand_d;
			end
			OP_FINISH: begin
				vel_q <= result;
			end
			OP_NONE: begin
			end
			default: begin
			end
		endcase
	end

	// speed state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == OP_FINISH) begin
				speed_q <= result;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.out_busy = out_valid_q && out_stall;
	assign out_valid = out_valid_q;
	assign velocity_ref = vel_q;

	`ASSERT_IMPLIES(a_valid_after_finish, clk, arst_n, $rose(out_valid_q), $past(cmd.op == OP_FINISH))
	`ASSERT_IMPLIES(a_vel_under_max, clk, arst_n, out_valid_q, vel_q <= max_q)

endmodule

`default_nettype wire

/* rtl/trapezoid_velocity_profile.sv */
// Each accepted position request is processed in turn: load, three passes through
// the shared 32x32 multiplier, then compare, update and finish steps; a new
// request is taken only after the last one finishes (in_stall high until then).
// A result held by out_stall delays the next update until it is taken.
// Reset (arst_n low): speed 0, registers to defaults, no result pending.
// ----------------------------------------------------------------------------
// trapezoid_velocity_profile
// Trapezoidal velocity command from measured position, one per control tick.
// ----------------------------------------------------------------------------
`default_nettype none

module trapezoid_velocity_profile (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [tvp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]                   cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic signed [31:0]            position,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [31:0]                        velocity_ref
);
	import tvp_pkg::*;

	logic signed [31:0] target_q;
	logic [31:0]        max_q;
	logic [31:0]        accel_q;
	logic [15:0]        tick_q;

	dp_cmd_t    cmd;
	dp_status_t status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			max_q <= '0;
			accel_q <= ACCEL_RESET;
			tick_q <= TICK_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TARGET:  target_q <= cfg_data;
				REG_MAX_VEL: max_q <= cfg_data;
				REG_ACCEL:   accel_q <= cfg_data;
				REG_TICK:    tick_q <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	tvp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	tvp_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.position     (position),
		.target_q     (target_q),
		.max_q        (max_q),
		.accel_q      (accel_q),
		.tick_q       (tick_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.velocity_ref (velocity_ref)
	);

endmodule

`default_nettype wire
